// ===== hw/rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue with random removal.
// Holds field widths, parameter defaults, request and cell codes, and the FSM states.
// Depends on nothing; every other file of the block depends on it.
package deq_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_ITEM_WIDTH = 32;
  localparam int DEF_RAND_LIMIT = 32767;

  // Fixed widths of the channel fields.
  localparam int REQ_W   = 2;
  localparam int VALUE_W = 32;
  localparam int DRAW_W  = 15;
  localparam int COUNT_W = 5;
  localparam int RIDX_W  = 4;

  // Widths of the broadcast to the cells, sized for the largest capacity (1024).
  localparam int MAX_CNT_W = 11;
  localparam int MAX_IDX_W = 10;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_REMOVE     = 2'd2,
    REQ_READ       = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_REMOVE
  } cell_op_t;

  // Command broadcast to every cell in a cycle.
  typedef struct packed {
    cell_op_t               op;
    logic [MAX_CNT_W-1:0]   count;
    logic [MAX_IDX_W-1:0]   idx;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EXEC,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/deq_if.sv =====
// Valid/ready channel interfaces for the request and result sides of the queue.
// Depends on deq_pkg for the field widths.
interface deq_in_if;
  import deq_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [VALUE_W-1:0] item_value;
  logic [DRAW_W-1:0]  random_draw;

  modport source (output valid, output req_type, output item_value, output random_draw,
                  input ready);
  modport sink   (input valid, input req_type, input item_value, input random_draw,
                  output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [VALUE_W-1:0] front_item;
  logic [VALUE_W-1:0] rear_item;
  logic [COUNT_W-1:0] entry_count;
  logic [RIDX_W-1:0]  removed_index;

  modport source (output valid, output status, output front_item, output rear_item,
                  output entry_count, output removed_index, input ready);
  modport sink   (input valid, input status, input front_item, input rear_item,
                  input entry_count, input removed_index, output ready);
endinterface

// ===== hw/rtl/deq_cell.sv =====
// One storage cell of the queue: holds the entry at a fixed position.
// Decodes the broadcast command locally. Depends on deq_pkg.
module deq_cell #(
  parameter int POS        = 0,
  parameter int ITEM_WIDTH = deq_pkg::DEF_ITEM_WIDTH
) (
  input  logic                  clk,
  input  deq_pkg::cell_cmd_t    cmd,
  input  logic [ITEM_WIDTH-1:0] new_item,
  input  logic [ITEM_WIDTH-1:0] left_item,
  input  logic [ITEM_WIDTH-1:0] right_item,
  output logic [ITEM_WIDTH-1:0] item,
  output logic [ITEM_WIDTH-1:0] rear_tap
);
  import deq_pkg::*;

  localparam logic [MAX_CNT_W-1:0] POS_C  = MAX_CNT_W'(POS);
  localparam logic [MAX_CNT_W-1:0] POS_N  = MAX_CNT_W'(POS + 1);

  logic [ITEM_WIDTH-1:0] item_r;
  logic [ITEM_WIDTH-1:0] item_nxt;

  always_comb begin
    item_nxt = item_r;
    case (cmd.op)
      OP_PUSH_FRONT: begin
        if (POS == 0) begin
          item_nxt = new_item;
        end else if (POS_C <= cmd.count) begin
          item_nxt = left_item;
        end
      end
      OP_PUSH_REAR: begin
        if (POS_C == cmd.count) begin
          item_nxt = new_item;
        end
      end
      OP_REMOVE: begin
        // Entries behind the removed one move one place toward the front.
        if ((POS_C >= MAX_CNT_W'(cmd.idx)) && (POS_N < cmd.count)) begin
          item_nxt = right_item;
        end
      end
      default: begin
        item_nxt = item_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item     = item_r;
  assign rear_tap = (POS_N == cmd.count) ? item_r : '0;

endmodule

// ===== hw/rtl/deq_div.sv =====
// Division of the scaled draw by the constant draw limit, done by multiplying with
// its rounded-up reciprocal; the product is registered and ready in the cycle after start.
// Depends on deq_pkg for the default draw limit.
module deq_div #(
  parameter int PW         = 20,
  parameter int RAND_LIMIT = deq_pkg::DEF_RAND_LIMIT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  output logic          done,
  output logic [PW-1:0] quotient
);

  // With a shift of PW plus the rounded-up log2 of the limit, the rounded-up
  // reciprocal gives the exact floor quotient for every dividend below 2**PW.
  localparam int LB = $clog2(RAND_LIMIT);
  localparam int SH = PW + LB;
  localparam int MW = PW + 2;
  localparam int XW = PW + MW;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(RAND_LIMIT) - 64'd1) / 64'(RAND_LIMIT);
  localparam logic [MW-1:0] RECIP_C = RECIP[MW-1:0];

  logic [XW-1:0] prod_r, prod_nxt;
  logic          done_r;

  always_comb begin
    prod_nxt = prod_r;
    if (start) begin
      prod_nxt = XW'(dividend) * XW'(RECIP_C);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign done     = done_r;
  assign quotient = PW'(prod_r >> SH);

endmodule

// ===== hw/rtl/deque_with_random_removal.sv =====
// Top level of the double-ended queue with removal at a random position.
// Depends on deq_pkg, deq_if (channel interfaces), deq_cell and deq_div.
//
//   Channel   Direction  Handshake          Carries
//   in_chan   sink       valid/ready        req_type, item_value, random_draw
//   out_chan  source     valid/ready        status, front/rear item, count, index
//
// A request passes through ST_IDLE (acceptance), ST_EXEC (update of the cells) and
// ST_OUT (forming the result) before the next one can be taken. A removal from a
// queue of three or more entries also passes through ST_MUL, to multiply by the
// reciprocal of the draw limit, and ST_DIV, to hand on the quotient.
// Reset (synchronous, active low) empties the queue; the entries are not cleared.
// A result waiting in the output register does not stop a new request being
// accepted; only the result stage waits for the output register to drain.
module deque_with_random_removal #(
  parameter int CAPACITY   = deq_pkg::DEF_CAPACITY,
  parameter int ITEM_WIDTH = deq_pkg::DEF_ITEM_WIDTH,
  parameter int RAND_LIMIT = deq_pkg::DEF_RAND_LIMIT
) (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_chan,
  deq_out_if.source  out_chan
);
  import deq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = CW + DRAW_W;
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);

  // Sequencer state.
  state_t state_r, state_nxt;

  // The request held while it is worked on.
  req_e_t                req_type_r;
  logic [ITEM_WIDTH-1:0] item_r;
  logic [DRAW_W-1:0]     draw_r;
  logic [PW-1:0]         prod_r;

  // Queue length and the per-request outcome.
  logic [CW-1:0] count_r, count_nxt;
  logic          status_r, status_nxt;
  logic [IW-1:0] removed_r, removed_nxt;

  // Output register.
  logic               out_valid_r;
  logic               out_status_r;
  logic [VALUE_W-1:0] out_front_r;
  logic [VALUE_W-1:0] out_rear_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [RIDX_W-1:0]  out_ridx_r;

  // Control decoded from the state.
  logic in_acc;
  logic div_start;
  logic div_done;
  logic exec_en;
  logic out_free;
  logic out_load;
  logic in_ready;
  logic need_div;

  logic [PW-1:0] div_q;
  logic [CW-1:0] cm1;
  logic          q_big;
  logic [IW-1:0] idx_sel;

  cell_cmd_t             cmd;
  logic [ITEM_WIDTH-1:0] cell_q  [CAPACITY];
  logic [ITEM_WIDTH-1:0] left_w  [CAPACITY];
  logic [ITEM_WIDTH-1:0] right_w [CAPACITY];
  logic [ITEM_WIDTH-1:0] tap_w   [CAPACITY];
  logic [ITEM_WIDTH-1:0] rear_any;

  assign in_acc   = in_chan.valid && in_ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // A removal needs the scaled draw only once the queue holds three or more entries.
  assign need_div = (req_e_t'(in_chan.req_type) == REQ_REMOVE) && (count_r >= CW'(3));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = need_div ? ST_MUL : ST_EXEC;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    exec_en   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_MUL: begin
        div_start = 1'b1;
      end
      ST_EXEC: begin
        exec_en = 1'b1;
      end
      ST_OUT: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request; the product of length and draw is registered before
  // it goes to the divider.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_type_r <= req_e_t'(in_chan.req_type);
      item_r     <= ITEM_WIDTH'(in_chan.item_value);
      draw_r     <= in_chan.random_draw;
      prod_r     <= PW'(count_r) * PW'(in_chan.random_draw);
    end
  end

  deq_div #(
    .PW         (PW),
    .RAND_LIMIT (RAND_LIMIT)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Choice of the entry to remove. With two entries the parity of the draw picks
  // the end: odd takes the front, even the rear. With three or more the quotient
  // is clamped to the last position.
  always_comb begin
    cm1   = count_r - CW'(1);
    q_big = div_q > PW'(cm1);
    if (count_r >= CW'(3)) begin
      idx_sel = q_big ? IW'(cm1) : IW'(div_q);
    end else if (count_r == CW'(2)) begin
      idx_sel = draw_r[0] ? '0 : IW'(1);
    end else begin
      idx_sel = '0;
    end
  end

  // Command to the cells and the new length. Outside the update cycle the cells
  // hold and the broadcast length drives their rear taps.
  always_comb begin
    cmd.op      = OP_HOLD;
    cmd.count   = MAX_CNT_W'(count_r);
    cmd.idx     = '0;
    count_nxt   = count_r;
    status_nxt  = 1'b0;
    removed_nxt = '0;
    if (exec_en) begin
      case (req_type_r)
        REQ_PUSH_FRONT: begin
          if (count_r == FULL) begin
            status_nxt = 1'b1;
          end else begin
            cmd.op    = OP_PUSH_FRONT;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_PUSH_REAR: begin
          if (count_r == FULL) begin
            status_nxt = 1'b1;
          end else begin
            cmd.op    = OP_PUSH_REAR;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_REMOVE: begin
          if (count_r == '0) begin
            status_nxt = 1'b1;
          end else begin
            cmd.op      = OP_REMOVE;
            cmd.idx     = MAX_IDX_W'(idx_sel);
            removed_nxt = idx_sel;
            count_nxt   = count_r - CW'(1);
          end
        end
        REQ_READ: begin
          status_nxt = (count_r == '0);
        end
        default: begin
          status_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
    end
  end

  // The row of cells; each neighbour pair is wired both ways so that entries can
  // move toward the rear on a front push and toward the front on a removal.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_w[k] = '0;
    end else begin : g_left
      assign left_w[k] = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w[k] = '0;
    end else begin : g_right
      assign right_w[k] = cell_q[k+1];
    end

    deq_cell #(
      .POS        (k),
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_item   (item_r),
      .left_item  (left_w[k]),
      .right_item (right_w[k]),
      .item       (cell_q[k]),
      .rear_tap   (tap_w[k])
    );
  end

  // Only the cell at the rear drives a non-zero tap, so the taps merge by OR.
  always_comb begin
    rear_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rear_any = rear_any | tap_w[k];
    end
  end

  // Output register: loaded in the result cycle, cleared once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_front_r  <= (count_r != '0) ? VALUE_W'(cell_q[0]) : '0;
      out_rear_r   <= VALUE_W'(rear_any);
      out_count_r  <= COUNT_W'(count_r);
      out_ridx_r   <= RIDX_W'(removed_r);
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.front_item    = out_front_r;
  assign out_chan.rear_item     = out_rear_r;
  assign out_chan.entry_count   = out_count_r;
  assign out_chan.removed_index = out_ridx_r;

endmodule

// ===== hw/rtl/deq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg for the field widths.
module deq_assertions #(
  parameter int CAPACITY = deq_pkg::DEF_CAPACITY
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        status,
  input logic [deq_pkg::VALUE_W-1:0] front_item,
  input logic [deq_pkg::VALUE_W-1:0] rear_item,
  input logic [deq_pkg::COUNT_W-1:0] entry_count,
  input logic [deq_pkg::RIDX_W-1:0]  removed_index
);
  import deq_pkg::*;

  // The count field is exact only while the capacity fits in it.
  localparam bit EXACT = CAPACITY < (1 << COUNT_W);

  // A result that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({status, front_item, rear_item,
                                                       entry_count, removed_index}))
    else $error("result changed while stalled");

  // One request at a time: after acceptance the block is busy.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in progress");

  // A failed request never reports a removed position.
  a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> removed_index == '0)
    else $error("failed request reports a removed index");

  // An empty queue shows zero at both ends.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    EXACT && out_valid && entry_count == '0 |-> front_item == '0 && rear_item == '0)
    else $error("empty queue shows a non-zero item");

  // With a single entry the front and the rear are the same entry.
  a_single_same: assert property (@(posedge clk) disable iff (!rst_n)
    EXACT && out_valid && entry_count == COUNT_W'(1) |-> front_item == rear_item)
    else $error("single entry differs between front and rear");

endmodule

bind deque_with_random_removal deq_assertions #(.CAPACITY(CAPACITY)) u_deq_assertions (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .status        (out_chan.status),
  .front_item    (out_chan.front_item),
  .rear_item     (out_chan.rear_item),
  .entry_count   (out_chan.entry_count),
  .removed_index (out_chan.removed_index)
);
